// File: hdl/min_window_all_values_top_defines.svh
// Assertion macros shared by the checker of the minimum covering window block.
`ifndef MIN_WINDOW_ALL_VALUES_TOP_DEFINES_SVH
`define MIN_WINDOW_ALL_VALUES_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define MWAV_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A condition that must be followed by another one at the next clock edge.
`define MWAV_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mwav_pkg.sv
// Package with the constants, types and state codes of the minimum covering window block.
package mwav_pkg;

    localparam int MAX_COLORS = 256;
    localparam int MAX_LEN    = 4096;

    localparam int VAL_W   = 9;
    localparam int OUT_W   = 13;
    localparam int ERR_W   = 2;
    localparam int SLOT_W  = $clog2(MAX_COLORS);
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int POS_W   = $clog2(MAX_LEN + 2);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int COV_W   = $clog2(MAX_COLORS + 1);

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LONG  = 2'd2;

    localparam int FLAG_RANGE = 0;
    localparam int FLAG_LONG  = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC,
        ST_CHECK,
        ST_WRD,
        ST_DEC,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [OUT_W-1:0] best_first;
        logic [OUT_W-1:0] best_last;
        logic             found;
        logic [ERR_W-1:0] error_code;
    } t_result;

endpackage

// File: hdl/mwav_in_if.sv
// Input channel interface carrying one sequence element per beat.
interface mwav_in_if;
    logic                       valid;
    logic                       ready;
    logic [mwav_pkg::VAL_W-1:0] value;
    logic                       last;

    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

// File: hdl/mwav_out_if.sv
// Output channel interface carrying one window result per beat.
interface mwav_out_if;
    logic                       valid;
    logic                       ready;
    logic [mwav_pkg::OUT_W-1:0] best_first;
    logic [mwav_pkg::OUT_W-1:0] best_last;
    logic                       found;
    logic [mwav_pkg::ERR_W-1:0] error_code;

    modport source (output valid, output best_first, output best_last, output found,
                    output error_code, input ready);
    modport sink (input valid, input best_first, input best_last, input found,
                  input error_code, output ready);
endinterface

// File: hdl/mwav_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module mwav_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/mwav_core.sv
// Sequencer and datapath that run the two-pointer window over the count and window memories.
module mwav_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [mwav_pkg::VAL_W-1:0]   i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [mwav_pkg::VAL_W-1:0]   i_in_value,
    input  logic                         i_in_last,
    input  logic                         i_res_free,
    output logic                         o_res_load,
    output mwav_pkg::t_result            o_res
);

    mwav_pkg::t_state r_state, n_state;

    logic [mwav_pkg::VAL_W-1:0]  r_num_colors, n_num_colors;
    logic [mwav_pkg::POS_W-1:0]  r_right, n_right;
    logic [mwav_pkg::POS_W-1:0]  r_left, n_left;
    logic [mwav_pkg::COV_W-1:0]  r_covered, n_covered;
    logic [mwav_pkg::POS_W-1:0]  r_best_len, n_best_len;
    logic [mwav_pkg::IDX_W-1:0]  r_best_left, n_best_left;
    logic [mwav_pkg::IDX_W-1:0]  r_best_right, n_best_right;
    logic [mwav_pkg::ERR_W-1:0]  r_err, n_err;
    logic                        r_last_pend, n_last_pend;
    logic [mwav_pkg::SLOT_W-1:0] r_slot;
    logic [mwav_pkg::MAX_COLORS-1:0] r_cnt_vld, n_cnt_vld;
    logic                        r_rd_vld;

    logic                        accept;
    logic                        bad_range;
    logic                        too_long;
    logic                        take;
    logic                        shrink;
    logic [mwav_pkg::POS_W-1:0]  win_len;

    logic                        win_we;
    logic [mwav_pkg::VAL_W-1:0]  win_rdata;
    logic                        cnt_we;
    logic [mwav_pkg::SLOT_W-1:0] cnt_raddr;
    logic [mwav_pkg::CNT_W-1:0]  cnt_rdata;
    logic [mwav_pkg::CNT_W-1:0]  cnt_cur;
    logic [mwav_pkg::CNT_W-1:0]  cnt_wdata;
    logic                        found;

    assign accept    = i_in_valid && o_in_ready;
    assign bad_range = (i_in_value == '0) || (i_in_value > r_num_colors)
                       || (i_in_value > mwav_pkg::VAL_W'(mwav_pkg::MAX_COLORS));
    assign too_long  = r_right >= mwav_pkg::POS_W'(mwav_pkg::MAX_LEN);
    assign take      = accept && !bad_range && !too_long;
    assign shrink    = (mwav_pkg::VAL_W'(r_covered) == r_num_colors) && (r_left < r_right);
    assign win_len   = r_right - r_left;
    assign cnt_cur   = r_rd_vld ? cnt_rdata : '0;

    mwav_ram #(
        .WIDTH (mwav_pkg::VAL_W),
        .DEPTH (mwav_pkg::MAX_LEN)
    ) u_win_ram (
        .i_clk     (i_clk),
        .i_wr_en   (win_we),
        .i_wr_addr (r_right[mwav_pkg::IDX_W-1:0]),
        .i_wr_data (i_in_value),
        .i_rd_addr (r_left[mwav_pkg::IDX_W-1:0]),
        .o_rd_data (win_rdata)
    );

    mwav_ram #(
        .WIDTH (mwav_pkg::CNT_W),
        .DEPTH (mwav_pkg::MAX_COLORS)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_we),
        .i_wr_addr (r_slot),
        .i_wr_data (cnt_wdata),
        .i_rd_addr (cnt_raddr),
        .o_rd_data (cnt_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            mwav_pkg::ST_IDLE: begin
                if (take) begin
                    n_state = mwav_pkg::ST_INC;
                end else if (accept && i_in_last) begin
                    n_state = mwav_pkg::ST_FIN;
                end
            end
            mwav_pkg::ST_INC: begin
                n_state = mwav_pkg::ST_CHECK;
            end
            mwav_pkg::ST_CHECK: begin
                if (shrink) begin
                    n_state = mwav_pkg::ST_WRD;
                end else if (r_last_pend) begin
                    n_state = mwav_pkg::ST_FIN;
                end else begin
                    n_state = mwav_pkg::ST_IDLE;
                end
            end
            mwav_pkg::ST_WRD: begin
                n_state = mwav_pkg::ST_DEC;
            end
            mwav_pkg::ST_DEC: begin
                n_state = mwav_pkg::ST_CHECK;
            end
            mwav_pkg::ST_FIN: begin
                if (i_res_free) begin
                    n_state = mwav_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mwav_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_res_load = 1'b0;
        win_we     = 1'b0;
        cnt_we     = 1'b0;
        cnt_raddr  = mwav_pkg::SLOT_W'(i_in_value - mwav_pkg::VAL_W'(1));
        cnt_wdata  = cnt_cur + mwav_pkg::CNT_W'(1);
        case (r_state)
            mwav_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                win_we     = take;
            end
            mwav_pkg::ST_INC: begin
                cnt_we = 1'b1;
            end
            mwav_pkg::ST_WRD: begin
                cnt_raddr = mwav_pkg::SLOT_W'(win_rdata - mwav_pkg::VAL_W'(1));
            end
            mwav_pkg::ST_DEC: begin
                cnt_we    = 1'b1;
                cnt_wdata = (cnt_cur != '0) ? cnt_cur - mwav_pkg::CNT_W'(1) : cnt_cur;
            end
            mwav_pkg::ST_FIN: begin
                o_res_load = i_res_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_num_colors = i_cfg_wr_en ? i_cfg_wr_data : r_num_colors;
        n_right      = r_right;
        n_left       = r_left;
        n_covered    = r_covered;
        n_best_len   = r_best_len;
        n_best_left  = r_best_left;
        n_best_right = r_best_right;
        n_err        = r_err;
        n_last_pend  = r_last_pend;
        n_cnt_vld    = r_cnt_vld;
        if (cnt_we) begin
            n_cnt_vld[r_slot] = 1'b1;
        end
        case (r_state)
            mwav_pkg::ST_IDLE: begin
                if (accept) begin
                    n_last_pend = i_in_last;
                    if (bad_range) begin
                        n_err[mwav_pkg::FLAG_RANGE] = 1'b1;
                    end else if (too_long) begin
                        n_err[mwav_pkg::FLAG_LONG] = 1'b1;
                    end
                end
            end
            mwav_pkg::ST_INC: begin
                n_right = r_right + mwav_pkg::POS_W'(1);
                if (cnt_cur == '0) begin
                    n_covered = r_covered + mwav_pkg::COV_W'(1);
                end
            end
            mwav_pkg::ST_CHECK: begin
                if (shrink && (win_len < r_best_len)) begin
                    n_best_len   = win_len;
                    n_best_left  = r_left[mwav_pkg::IDX_W-1:0];
                    n_best_right = mwav_pkg::IDX_W'(r_right - mwav_pkg::POS_W'(1));
                end
            end
            mwav_pkg::ST_DEC: begin
                n_left = r_left + mwav_pkg::POS_W'(1);
                if ((cnt_wdata == '0) && (r_covered != '0)) begin
                    n_covered = r_covered - mwav_pkg::COV_W'(1);
                end
            end
            mwav_pkg::ST_FIN: begin
                if (i_res_free) begin
                    n_right      = '0;
                    n_left       = '0;
                    n_covered    = '0;
                    n_best_len   = mwav_pkg::POS_W'(mwav_pkg::MAX_LEN + 1);
                    n_best_left  = '0;
                    n_best_right = '0;
                    n_err        = '0;
                    n_last_pend  = 1'b0;
                    n_cnt_vld    = '0;
                end
            end
            default: begin
                n_last_pend = r_last_pend;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mwav_pkg::ST_IDLE;
            r_num_colors <= mwav_pkg::VAL_W'(1);
            r_right      <= '0;
            r_left       <= '0;
            r_covered    <= '0;
            r_best_len   <= mwav_pkg::POS_W'(mwav_pkg::MAX_LEN + 1);
            r_best_left  <= '0;
            r_best_right <= '0;
            r_err        <= '0;
            r_last_pend  <= 1'b0;
            r_cnt_vld    <= '0;
        end else begin
            r_state      <= n_state;
            r_num_colors <= n_num_colors;
            r_right      <= n_right;
            r_left       <= n_left;
            r_covered    <= n_covered;
            r_best_len   <= n_best_len;
            r_best_left  <= n_best_left;
            r_best_right <= n_best_right;
            r_err        <= n_err;
            r_last_pend  <= n_last_pend;
            r_cnt_vld    <= n_cnt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot   <= cnt_raddr;
        r_rd_vld <= r_cnt_vld[cnt_raddr];
    end

    assign found = r_best_len <= mwav_pkg::POS_W'(mwav_pkg::MAX_LEN);

    always_comb begin
        o_res.found      = found;
        o_res.best_first = found ? mwav_pkg::OUT_W'(r_best_left) + mwav_pkg::OUT_W'(1)
                                 : mwav_pkg::OUT_W'(1);
        o_res.best_last  = found ? mwav_pkg::OUT_W'(r_best_right) + mwav_pkg::OUT_W'(1)
                                 : mwav_pkg::OUT_W'(1);
        if (r_err[mwav_pkg::FLAG_LONG]) begin
            o_res.error_code = mwav_pkg::ERR_LONG;
        end else if (r_err[mwav_pkg::FLAG_RANGE]) begin
            o_res.error_code = mwav_pkg::ERR_RANGE;
        end else begin
            o_res.error_code = mwav_pkg::ERR_NONE;
        end
    end

endmodule

// File: hdl/min_window_all_values_top.sv
// Top level of the minimum covering window block with its output register.
//
// Elements arrive on i_in, one label per beat, and the beat with last set ends a sequence.
// After the last beat one result beat leaves on o_out: the 1-based first and last positions
// of the shortest run holding every label from 1 to num_colors, found, and error_code.
// The user must write num_colors through i_cfg_wr_en and i_cfg_wr_data only while the
// block is idle; the block itself does not enforce this. A dropped element (bad label or
// sequence too long) is accepted in ST_IDLE and sets its error flag. A kept element passes
// through ST_INC and ST_CHECK, then through ST_WRD, ST_DEC and ST_CHECK for each element
// that then leaves the window on the left; every element leaves at most once, and a new
// element is taken only in ST_IDLE. ST_FIN loads the result into the output register.
// Reset clears the pointers, counts, flags and output valid flag and sets num_colors to 1.
// The result waits in the output register while o_out.ready is low; the next sequence is
// taken meanwhile, and its own result waits until the register is free.
module min_window_all_values_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [mwav_pkg::VAL_W-1:0] i_cfg_wr_data,
    mwav_in_if.sink                    i_in,
    mwav_out_if.source                 o_out
);

    logic              res_free;
    logic              res_load;
    mwav_pkg::t_result res;
    mwav_pkg::t_result r_res;
    logic              r_out_vld;

    assign res_free = !r_out_vld || o_out.ready;

    mwav_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (i_in.ready),
        .i_in_value    (i_in.value),
        .i_in_last     (i_in.last),
        .i_res_free    (res_free),
        .o_res_load    (res_load),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res <= res;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.best_first = r_res.best_first;
    assign o_out.best_last  = r_res.best_last;
    assign o_out.found      = r_res.found;
    assign o_out.error_code = r_res.error_code;

endmodule

// File: hdl/mwav_check.sv
// Port-level checker for the minimum covering window block and its bind statement.
`include "min_window_all_values_top_defines.svh"

module mwav_check (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [mwav_pkg::OUT_W-1:0] i_out_best_first,
    input logic [mwav_pkg::OUT_W-1:0] i_out_best_last,
    input logic                       i_out_found,
    input logic [mwav_pkg::ERR_W-1:0] i_out_error_code
);

    `MWAV_CHECK_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable({i_out_best_first, i_out_best_last, i_out_found, i_out_error_code}), "Stalled result beat changed.")

    `MWAV_CHECK(a_no_run, i_out_valid && !i_out_found |-> (i_out_best_first == 13'd1) && (i_out_best_last == 13'd1), "A result without a covering run must report positions 1 and 1.")

    `MWAV_CHECK(a_run_order, i_out_valid && i_out_found |-> (i_out_best_first != 13'd0) && (i_out_best_first <= i_out_best_last), "A covering run must start at or before its end.")

    `MWAV_CHECK(a_reset_quiet, $past(!i_rst_n) |-> !i_out_valid, "No result beat may follow reset directly.")

endmodule

bind min_window_all_values_top mwav_check u_mwav_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_best_first (o_out.best_first),
    .i_out_best_last  (o_out.best_last),
    .i_out_found      (o_out.found),
    .i_out_error_code (o_out.error_code)
);
